### rtl/pol_pkg.sv
// Shared types and codes of the priority-ordered lock.
`default_nettype none

package pol_pkg;

   // Request commands.
   typedef enum logic [1:0] {
      CMD_LOCK    = 2'd0,
      CMD_UNLOCK  = 2'd1,
      CMD_TRYLOCK = 2'd2
   } command_type;

   // Result status codes.
   typedef enum logic [2:0] {
      STS_GRANTED    = 3'd0,
      STS_QUEUED     = 3'd1,
      STS_BUSY       = 3'd2,
      STS_NOT_OWNER  = 3'd3,
      STS_QUEUE_FULL = 3'd4,
      STS_RELEASED   = 3'd5,
      STS_HANDED     = 3'd6
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN
   } state_type;

   // Broadcast from the sequencer to every wait cell.
   typedef struct packed {
      logic insert;   // load the new waiter into the cell at pos
      logic remove;   // cells at pos and above take their upper neighbor
   } cell_ctrl_type;

   localparam int unsigned CMD_BITS    = 2;
   localparam int unsigned STATUS_BITS = 3;
   localparam int unsigned COUNT_BITS  = 5;

endpackage

`default_nettype wire

### rtl/pol_cell.sv
// One wait-queue cell: holds a waiter and forwards the running best waiter.
`default_nettype none

module pol_cell #(
   parameter int unsigned ID_BITS   = 8,
   parameter int unsigned PRIO_BITS = 8,
   parameter int unsigned IDX_W     = 4,
   parameter int unsigned CELL_IDX  = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  prefer_low,
   input  wire pol_pkg::cell_ctrl_type ctrl,
   input  wire logic [IDX_W-1:0]      pos,
   input  wire logic [ID_BITS-1:0]    load_task,
   input  wire logic [PRIO_BITS-1:0]  load_prio,
   input  wire logic                  nb_present,
   input  wire logic [ID_BITS-1:0]    nb_task,
   input  wire logic [PRIO_BITS-1:0]  nb_prio,
   output logic                       present,
   output logic [ID_BITS-1:0]         task_id,
   output logic [PRIO_BITS-1:0]       prio,
   input  wire logic                  best_in_valid,
   input  wire logic [ID_BITS-1:0]    best_in_task,
   input  wire logic [PRIO_BITS-1:0]  best_in_prio,
   input  wire logic [IDX_W-1:0]      best_in_idx,
   output logic                       best_out_valid,
   output logic [ID_BITS-1:0]         best_out_task,
   output logic [PRIO_BITS-1:0]       best_out_prio,
   output logic [IDX_W-1:0]           best_out_idx
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic                 present_ff, present_in;
   logic [ID_BITS-1:0]   task_ff, task_in;
   logic [PRIO_BITS-1:0] prio_ff, prio_in;
   logic                 best_valid_ff;
   logic [ID_BITS-1:0]   best_task_ff;
   logic [PRIO_BITS-1:0] best_prio_ff;
   logic [IDX_W-1:0]     best_idx_ff;
   logic                 mine_better;

   always_comb begin
      present_in = present_ff;
      task_in    = task_ff;
      prio_in    = prio_ff;
      if (ctrl.remove && (MY_IDX >= pos)) begin
         // close the gap: take the upper neighbor's waiter
         present_in = nb_present;
         task_in    = nb_task;
         prio_in    = nb_prio;
      end else if (ctrl.insert && (MY_IDX == pos)) begin
         present_in = 1'b1;
         task_in    = load_task;
         prio_in    = load_prio;
      end
   end

   // strict compare keeps the earlier arrival on a tie
   always_comb begin
      mine_better = present_ff &&
         (!best_in_valid ||
          (prefer_low ? (prio_ff < best_in_prio) : (prio_ff > best_in_prio)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff    <= 1'b0;
         best_valid_ff <= 1'b0;
      end else begin
         present_ff    <= present_in;
         best_valid_ff <= best_in_valid | present_ff;
      end
      task_ff <= task_in;
      prio_ff <= prio_in;
      if (mine_better) begin
         best_task_ff <= task_ff;
         best_prio_ff <= prio_ff;
         best_idx_ff  <= MY_IDX;
      end else begin
         best_task_ff <= best_in_task;
         best_prio_ff <= best_in_prio;
         best_idx_ff  <= best_in_idx;
      end
   end

   assign present        = present_ff;
   assign task_id        = task_ff;
   assign prio           = prio_ff;
   assign best_out_valid = best_valid_ff;
   assign best_out_task  = best_task_ff;
   assign best_out_prio  = best_prio_ff;
   assign best_out_idx   = best_idx_ff;

endmodule

`default_nettype wire

### rtl/priority_ordered_lock.sv
// Top level of the priority-ordered lock: sequencer, owner, wait-cell chain.
//
//  channel  | direction | handshake                 | word contents (lsb first)
//  ---------+-----------+---------------------------+--------------------------------------
//  req_     | in        | req_tvalid / req_tready   | command, requester_id, priority_req
//  rsp_     | out       | rsp_tvalid / rsp_tready   | status, owner_id, owner_held,
//           |           |                           | waiting_count
//  csr_     | in        | csr_wr_en (no wait)       | prefer_low_value
//
// Steps: lock, trylock, a refused or freeing unlock go through accept, then
//   execute. An unlock that hands off adds a search state after execute: the
//   best-waiter search rides down the cell chain one cell a cycle.
// Reset: synchronous, clears owner, queue-present bits, count and handshakes.
// Stalls: a finished word waits in the output register; a new request is
//   accepted meanwhile and then holds in execute until the register frees.
`default_nettype none

module priority_ordered_lock #(
   parameter int unsigned MAX_WAITERS = 16,
   parameter int unsigned ID_BITS     = 8,
   parameter int unsigned PRIO_BITS   = 8,
   localparam int unsigned REQ_W       = pol_pkg::CMD_BITS + ID_BITS + PRIO_BITS,
   localparam int unsigned REQ_TDATA_W = ((REQ_W + 7) / 8) * 8,
   localparam int unsigned RSP_W       = pol_pkg::STATUS_BITS + ID_BITS + 1 +
                                         pol_pkg::COUNT_BITS,
   localparam int unsigned RSP_TDATA_W = ((RSP_W + 7) / 8) * 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // configuration
   input  wire logic                   csr_wr_en,
   input  wire logic [0:0]             csr_wr_data,   // prefer_low_value
   // request words
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [1:0] command, then requester_id, then priority_req, zero pad to bytes
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // result words
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [2:0] status, then owner_id, owner_held, waiting_count (5), zero pad
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   localparam int unsigned IDX_W       = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
   localparam int unsigned CNT_W       = $clog2(MAX_WAITERS + 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_WAITERS);
   localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(MAX_WAITERS - 1);

   // ---------------------------------------------------------------- registers
   pol_pkg::state_type   state_ff, state_in;
   logic                 prefer_low_ff;
   logic [ID_BITS-1:0]   owner_ff, owner_in;
   logic                 owner_valid_ff, owner_valid_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     scan_ff, scan_in;
   logic [1:0]           cmd_ff;
   logic [ID_BITS-1:0]   id_ff;
   logic [PRIO_BITS-1:0] prio_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // ---------------------------------------------------------------- cell chain
   pol_pkg::cell_ctrl_type cell_ctrl;
   logic [IDX_W-1:0]     cell_pos;
   logic [MAX_WAITERS-1:0] cell_present;
   logic [ID_BITS-1:0]   cell_task   [MAX_WAITERS];
   logic [PRIO_BITS-1:0] cell_prio   [MAX_WAITERS];
   logic [MAX_WAITERS-1:0] best_valid;
   logic [ID_BITS-1:0]   best_task   [MAX_WAITERS];
   logic [PRIO_BITS-1:0] best_prio   [MAX_WAITERS];
   logic [IDX_W-1:0]     best_idx    [MAX_WAITERS];

   // ---------------------------------------------------------------- helpers
   logic                 req_fire;
   logic                 out_free;
   logic                 result_fire;
   pol_pkg::status_type  status;
   logic [ID_BITS-1:0]   owner_out;
   logic [CNT_W+4:0]     count_ext;

   assign req_tready = (state_ff == pol_pkg::S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_WAITERS; gi++) begin : g_cell
         logic                 nb_present;
         logic [ID_BITS-1:0]   nb_task;
         logic [PRIO_BITS-1:0] nb_prio;
         logic                 bin_valid;
         logic [ID_BITS-1:0]   bin_task;
         logic [PRIO_BITS-1:0] bin_prio;
         logic [IDX_W-1:0]     bin_idx;

         if (gi == MAX_WAITERS - 1) begin : g_top_end
            assign nb_present = 1'b0;
            assign nb_task    = '0;
            assign nb_prio    = '0;
         end else begin : g_top_mid
            assign nb_present = cell_present[gi+1];
            assign nb_task    = cell_task[gi+1];
            assign nb_prio    = cell_prio[gi+1];
         end

         if (gi == 0) begin : g_best_head
            assign bin_valid = 1'b0;
            assign bin_task  = '0;
            assign bin_prio  = '0;
            assign bin_idx   = '0;
         end else begin : g_best_mid
            assign bin_valid = best_valid[gi-1];
            assign bin_task  = best_task[gi-1];
            assign bin_prio  = best_prio[gi-1];
            assign bin_idx   = best_idx[gi-1];
         end

         pol_cell #(
            .ID_BITS   (ID_BITS),
            .PRIO_BITS (PRIO_BITS),
            .IDX_W     (IDX_W),
            .CELL_IDX  (gi)
         ) u_cell (
            .clock          (clock),
            .reset          (reset),
            .prefer_low     (prefer_low_ff),
            .ctrl           (cell_ctrl),
            .pos            (cell_pos),
            .load_task      (id_ff),
            .load_prio      (prio_ff),
            .nb_present     (nb_present),
            .nb_task        (nb_task),
            .nb_prio        (nb_prio),
            .present        (cell_present[gi]),
            .task_id        (cell_task[gi]),
            .prio           (cell_prio[gi]),
            .best_in_valid  (bin_valid),
            .best_in_task   (bin_task),
            .best_in_prio   (bin_prio),
            .best_in_idx    (bin_idx),
            .best_out_valid (best_valid[gi]),
            .best_out_task  (best_task[gi]),
            .best_out_prio  (best_prio[gi]),
            .best_out_idx   (best_idx[gi])
         );
      end
   endgenerate

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in       = state_ff;
      owner_in       = owner_ff;
      owner_valid_in = owner_valid_ff;
      count_in       = count_ff;
      scan_in        = scan_ff;
      cell_ctrl      = '0;
      cell_pos       = '0;
      status         = pol_pkg::STS_BUSY;
      result_fire    = 1'b0;

      unique case (state_ff)
         pol_pkg::S_IDLE: begin
            if (req_fire) begin
               state_in = pol_pkg::S_EXEC;
            end
         end
         pol_pkg::S_EXEC: begin
            if (out_free) begin
               result_fire = 1'b1;
               state_in    = pol_pkg::S_IDLE;
               case (cmd_ff)
                  pol_pkg::CMD_LOCK: begin
                     if (!owner_valid_ff) begin
                        owner_in       = id_ff;
                        owner_valid_in = 1'b1;
                        status         = pol_pkg::STS_GRANTED;
                     end else if (count_ff == FULL_CNT) begin
                        status = pol_pkg::STS_QUEUE_FULL;
                     end else begin
                        // append at the tail to keep arrival order
                        cell_ctrl.insert = 1'b1;
                        cell_pos         = count_ff[IDX_W-1:0];
                        count_in         = count_ff + 1'b1;
                        status           = pol_pkg::STS_QUEUED;
                     end
                  end
                  pol_pkg::CMD_UNLOCK: begin
                     if (!owner_valid_ff || (owner_ff != id_ff)) begin
                        status = pol_pkg::STS_NOT_OWNER;
                     end else if (count_ff == '0) begin
                        owner_in       = '0;
                        owner_valid_in = 1'b0;
                        status         = pol_pkg::STS_RELEASED;
                     end else begin
                        // search for the top waiter before answering
                        result_fire = 1'b0;
                        scan_in     = '0;
                        state_in    = pol_pkg::S_SCAN;
                     end
                  end
                  pol_pkg::CMD_TRYLOCK: begin
                     if (!owner_valid_ff) begin
                        owner_in       = id_ff;
                        owner_valid_in = 1'b1;
                        status         = pol_pkg::STS_GRANTED;
                     end else begin
                        status = pol_pkg::STS_BUSY;
                     end
                  end
                  default: begin
                     status = pol_pkg::STS_BUSY;
                  end
               endcase
            end
         end
         pol_pkg::S_SCAN: begin
            if (scan_ff != SCAN_LAST) begin
               scan_in = scan_ff + 1'b1;
            end else if (out_free) begin
               // chain output is settled: hand off and close the gap
               result_fire      = 1'b1;
               state_in         = pol_pkg::S_IDLE;
               owner_in         = best_task[MAX_WAITERS-1];
               cell_ctrl.remove = 1'b1;
               cell_pos         = best_idx[MAX_WAITERS-1];
               count_in         = count_ff - 1'b1;
               status           = pol_pkg::STS_HANDED;
            end
         end
         default: begin
            state_in = pol_pkg::S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- result word
   assign owner_out = owner_valid_in ? owner_in : '0;
   assign count_ext = {5'b0, count_in};

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (result_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_TDATA_W'({count_ext[pol_pkg::COUNT_BITS-1:0],
                                      owner_valid_in, owner_out, status});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pol_pkg::S_IDLE;
         prefer_low_ff  <= 1'b0;
         owner_ff       <= '0;
         owner_valid_ff <= 1'b0;
         count_ff       <= '0;
         scan_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         owner_ff       <= owner_in;
         owner_valid_ff <= owner_valid_in;
         count_ff       <= count_in;
         scan_ff        <= scan_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            prefer_low_ff <= csr_wr_data[0];
         end
      end
      rsp_data_ff <= rsp_data_in;
      if (req_fire) begin
         cmd_ff  <= req_tdata[pol_pkg::CMD_BITS-1:0];
         id_ff   <= req_tdata[pol_pkg::CMD_BITS +: ID_BITS];
         prio_ff <= req_tdata[pol_pkg::CMD_BITS + ID_BITS +: PRIO_BITS];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   // queue never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("waiter count above capacity");

   // occupied cells match the count
   a_present_count: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_present) == int'(count_ff))
      else $error("present cells disagree with waiter count");

   // a finished scan always finds a waiter
   a_scan_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pol_pkg::S_SCAN && scan_ff == SCAN_LAST) |-> best_valid[MAX_WAITERS-1])
      else $error("handoff search found no waiter");

   // waiters only queue behind an owner
   a_queue_needs_owner: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> owner_valid_ff)
      else $error("waiters queued on a free lock");

   // a result word is produced in the cycle after it is decided
   a_result_out: assert property (@(posedge clock) disable iff (reset)
      result_fire |=> rsp_tvalid)
      else $error("decided result not presented");

endmodule

`default_nettype wire
